// ===== sv/token_min_p_sampler_core_assert.svh =====
// Assertion macros for the token sampler core.
// Used by the top level only; needs a clock and an active-low reset argument.
`ifndef TOKEN_MIN_P_SAMPLER_CORE_ASSERT_SVH
`define TOKEN_MIN_P_SAMPLER_CORE_ASSERT_SVH

// a implies b in the same cycle
`define TSAMP_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("assertion failed");

// a implies b in the next cycle
`define TSAMP_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("assertion failed");

`endif

// ===== sv/tsamp_pkg.sv =====
// Shared types, constants and exp tables for the token sampler.
// No dependencies.
package tsamp_pkg;

    localparam int VOCAB_DEPTH_DEF = 262144;
    localparam int IDX_W = 20;
    localparam int CNT_W = 21;
    localparam int TOKEN_W = 18;

    localparam logic [1:0] CFG_MODE = 2'd0;
    localparam logic [1:0] CFG_INV_TEMP = 2'd1;
    localparam logic [1:0] CFG_MIN_P = 2'd2;

    localparam logic RST_MODE = 1'b1;
    localparam logic [15:0] RST_INV_TEMP = 16'd256;
    localparam logic [15:0] RST_MIN_P = 16'd3277;

    localparam logic MODE_GREEDY = 1'b0;

    typedef struct packed {
        logic               mode;
        logic signed [15:0] peak;
        logic [IDX_W-1:0]   peak_idx;
        logic [CNT_W-1:0]   count;
        logic [15:0]        udraw;
    } t_job;

    typedef enum logic [2:0] {
        B_IDLE,
        B_PASS1,
        B_DRAIN1,
        B_PRE,
        B_PRE2,
        B_PASS2,
        B_DONE
    } t_bstate;

    function automatic logic [16:0] exp_int(input logic [3:0] i);
        logic [16:0] t;
        unique case (i)
            4'd0:  t = 17'd65536;
            4'd1:  t = 17'd24109;
            4'd2:  t = 17'd8869;
            4'd3:  t = 17'd3263;
            4'd4:  t = 17'd1200;
            4'd5:  t = 17'd442;
            4'd6:  t = 17'd162;
            4'd7:  t = 17'd60;
            4'd8:  t = 17'd22;
            4'd9:  t = 17'd8;
            4'd10: t = 17'd3;
            4'd11: t = 17'd1;
            default: t = 17'd0;
        endcase
        return t;
    endfunction

    function automatic logic [16:0] exp_hi(input logic [3:0] i);
        logic [16:0] t;
        unique case (i)
            4'd0:  t = 17'd65536;
            4'd1:  t = 17'd61565;
            4'd2:  t = 17'd57835;
            4'd3:  t = 17'd54331;
            4'd4:  t = 17'd51039;
            4'd5:  t = 17'd47947;
            4'd6:  t = 17'd45042;
            4'd7:  t = 17'd42313;
            4'd8:  t = 17'd39750;
            4'd9:  t = 17'd37341;
            4'd10: t = 17'd35079;
            4'd11: t = 17'd32954;
            4'd12: t = 17'd30957;
            4'd13: t = 17'd29081;
            4'd14: t = 17'd27319;
            default: t = 17'd25664;
        endcase
        return t;
    endfunction

    function automatic logic [16:0] exp_lo(input logic [3:0] i);
        logic [16:0] t;
        unique case (i)
            4'd0:  t = 17'd65536;
            4'd1:  t = 17'd65280;
            4'd2:  t = 17'd65026;
            4'd3:  t = 17'd64772;
            4'd4:  t = 17'd64520;
            4'd5:  t = 17'd64268;
            4'd6:  t = 17'd64018;
            4'd7:  t = 17'd63768;
            4'd8:  t = 17'd63520;
            4'd9:  t = 17'd63272;
            4'd10: t = 17'd63025;
            4'd11: t = 17'd62780;
            4'd12: t = 17'd62535;
            4'd13: t = 17'd62291;
            4'd14: t = 17'd62048;
            default: t = 17'd61806;
        endcase
        return t;
    endfunction

    // rounded Q0.16 product
    function automatic logic [15:0] qmul(input logic [15:0] a, input logic [16:0] t);
        logic [33:0] p;
        p = 34'(a) * 34'(t) + 34'd32768;
        return p[31:16];
    endfunction

endpackage

// ===== sv/tsamp_fifo.sv =====
// Two-entry job queue between the load front and the sampling back end.
// Depends on tsamp_pkg.
module tsamp_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tsamp_pkg::t_job   i_job,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output tsamp_pkg::t_job   o_job
);
    tsamp_pkg::t_job r_mem [2];
    logic r_wp;
    logic r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    assign o_full = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job = r_mem[r_rp];
endmodule

// ===== sv/tsamp_front.sv =====
// Load front: takes logits, drives the logit store write port, tracks the peak
// and queues one job per vector. Depends on tsamp_pkg.
module tsamp_front #(
    parameter int VOCAB_DEPTH = tsamp_pkg::VOCAB_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [15:0]                i_logit,
    input  logic [15:0]                       i_udraw,
    input  logic                              i_last,
    input  logic                              i_mode,
    output logic                              o_wr_en,
    output logic [$clog2(VOCAB_DEPTH)-1:0]    o_wr_addr,
    output logic [15:0]                       o_wr_data,
    output logic                              o_push,
    output tsamp_pkg::t_job                   o_job,
    input  logic                              i_full,
    input  logic                              i_release
);
    localparam int AW = $clog2(VOCAB_DEPTH);
    localparam int CW = $clog2(VOCAB_DEPTH + 1);

    logic [CW-1:0]      r_count;
    logic signed [15:0] r_peak;
    logic [AW-1:0]      r_peak_idx;
    logic               r_hold;

    logic w_acc;
    logic w_store;
    logic w_upd;
    logic [CW-1:0] w_count;

    always_comb begin
        o_ready = !r_hold && !i_full;
        w_acc = i_valid && o_ready;
        w_store = (r_count < CW'(VOCAB_DEPTH));
        w_upd = w_store && (i_logit > r_peak);
        w_count = w_store ? r_count + CW'(1) : r_count;
        o_wr_en = w_acc && w_store;
        o_wr_addr = r_count[AW-1:0];
        o_wr_data = i_logit;
        o_push = w_acc && i_last;
        o_job.mode = i_mode;
        o_job.peak = w_upd ? i_logit : r_peak;
        o_job.peak_idx = w_upd ? tsamp_pkg::IDX_W'(r_count[AW-1:0])
                               : tsamp_pkg::IDX_W'(r_peak_idx);
        o_job.count = tsamp_pkg::CNT_W'(w_count);
        o_job.udraw = i_udraw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_peak <= 16'sh8000;
            r_peak_idx <= '0;
            r_hold <= 1'b0;
        end else begin
            if (i_release) r_hold <= 1'b0;
            if (w_acc) begin
                if (i_last) begin
                    r_count <= '0;
                    r_peak <= 16'sh8000;
                    r_peak_idx <= '0;
                    r_hold <= 1'b1;
                end else begin
                    r_count <= w_count;
                    if (w_upd) begin
                        r_peak <= i_logit;
                        r_peak_idx <= r_count[AW-1:0];
                    end
                end
            end
        end
    end
endmodule

// ===== sv/tsamp_back.sv =====
// Sampling back end: owns the logit and weight stores, computes weights in a
// pipelined pass and walks the cumulative sum in a second pass. Depends on tsamp_pkg.
module tsamp_back #(
    parameter int VOCAB_DEPTH = tsamp_pkg::VOCAB_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_job_valid,
    input  tsamp_pkg::t_job                   i_job,
    output logic                              o_pop,
    output logic                              o_release,
    input  logic                              i_wr_en,
    input  logic [$clog2(VOCAB_DEPTH)-1:0]    i_wr_addr,
    input  logic [15:0]                       i_wr_data,
    input  logic [15:0]                       i_inv_temp,
    input  logic [15:0]                       i_min_p,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [tsamp_pkg::TOKEN_W-1:0]     o_index
);
    localparam int AW = $clog2(VOCAB_DEPTH);
    localparam int CW = $clog2(VOCAB_DEPTH + 1);

    tsamp_pkg::t_bstate r_state;
    tsamp_pkg::t_bstate n_state;

    logic [15:0] r_logit_mem [VOCAB_DEPTH];
    logic [15:0] r_weight_mem [VOCAB_DEPTH];
    logic [15:0] r_rd_logit;
    logic [15:0] r_rd_w;

    logic signed [15:0] r_peak;
    logic [CW-1:0]      r_count;
    logic [15:0]        r_u;
    logic [CW-1:0]      r_i;
    logic [AW-1:0]      r_res;
    logic [AW-1:0]      r_last_cand;
    logic [33:0]        r_total;
    logic [33:0]        r_cum;
    logic [49:0]        r_utot;
    logic [31:0]        r_thr;
    logic               r_out_valid;
    logic [tsamp_pkg::TOKEN_W-1:0] r_out_idx;

    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic [AW-1:0] r_a1, r_a2, r_a3, r_a4, r_a5;
    logic [31:0] r_prod;
    logic [15:0] r_w1, r_w2, r_w3;
    logic [7:0]  r_slo;
    logic [3:0]  r_slo4;
    logic        r_z3, r_z4;

    logic          r_q1;
    logic [AW-1:0] r_qa;

    logic [CW-1:0] w_last_i;
    logic [15:0]   w_diff;
    logic [15:0]   w_s;
    logic          w_cand;
    logic [33:0]   w_cum_new;
    logic          w_hit;
    logic          w_end;

    always_comb begin
        w_last_i = r_count - CW'(1);
        w_diff = 16'(r_peak) - r_rd_logit;
        w_s = (r_prod[31:24] != 8'd0) ? 16'hFFFF : r_prod[23:8];
        w_cand = ({r_rd_w, 16'd0} >= r_thr);
        w_cum_new = r_cum + 34'(r_rd_w);
        w_hit = r_q1 && w_cand && ({w_cum_new, 16'd0} > r_utot);
        w_end = r_q1 && (r_qa == w_last_i[AW-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) r_logit_mem[i_wr_addr] <= i_wr_data;
        r_rd_logit <= r_logit_mem[r_i[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (r_v5) r_weight_mem[r_a5] <= r_w3;
        r_rd_w <= r_weight_mem[r_i[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= tsamp_pkg::B_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_pop = 1'b0;
        o_release = 1'b0;
        unique case (r_state)
            tsamp_pkg::B_IDLE: begin
                if (i_job_valid && !r_out_valid) begin
                    o_pop = 1'b1;
                    n_state = (i_job.mode == tsamp_pkg::MODE_GREEDY) ? tsamp_pkg::B_DONE
                                                                    : tsamp_pkg::B_PASS1;
                end
            end
            tsamp_pkg::B_PASS1: begin
                if (r_i == w_last_i) n_state = tsamp_pkg::B_DRAIN1;
            end
            tsamp_pkg::B_DRAIN1: begin
                if (!(r_v1 || r_v2 || r_v3 || r_v4 || r_v5)) n_state = tsamp_pkg::B_PRE;
            end
            tsamp_pkg::B_PRE: n_state = tsamp_pkg::B_PRE2;
            tsamp_pkg::B_PRE2: n_state = tsamp_pkg::B_PASS2;
            tsamp_pkg::B_PASS2: begin
                if (w_hit || w_end) n_state = tsamp_pkg::B_DONE;
            end
            tsamp_pkg::B_DONE: begin
                o_release = 1'b1;
                n_state = tsamp_pkg::B_IDLE;
            end
            default: n_state = tsamp_pkg::B_IDLE;
        endcase
    end

    // control: pipeline valids and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_q1 <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v1 <= (r_state == tsamp_pkg::B_PASS1);
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_q1 <= (r_state == tsamp_pkg::B_PASS2) && (r_i < r_count) && !w_hit && !w_end;
            if (r_state == tsamp_pkg::B_DONE) r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_a1 <= r_i[AW-1:0];
        r_a2 <= r_a1;
        r_a3 <= r_a2;
        r_a4 <= r_a3;
        r_a5 <= r_a4;
        r_qa <= r_i[AW-1:0];

        r_prod <= w_diff * i_inv_temp;
        r_z3 <= (w_s[15:8] >= 8'd12);
        r_w1 <= tsamp_pkg::qmul(16'hFFFF, tsamp_pkg::exp_int(w_s[11:8]));
        r_slo <= w_s[7:0];
        r_z4 <= r_z3;
        r_w2 <= tsamp_pkg::qmul(r_w1, tsamp_pkg::exp_hi(r_slo[7:4]));
        r_slo4 <= r_slo[3:0];
        r_w3 <= r_z4 ? 16'd0 : tsamp_pkg::qmul(r_w2, tsamp_pkg::exp_lo(r_slo4));
        if (r_v5) r_total <= r_total + 34'(r_w3);

        if (r_state == tsamp_pkg::B_DONE) r_out_idx <= tsamp_pkg::TOKEN_W'(r_res);

        unique case (r_state)
            tsamp_pkg::B_IDLE: begin
                r_peak <= i_job.peak;
                r_count <= CW'(i_job.count);
                r_u <= i_job.udraw;
                r_res <= AW'(i_job.peak_idx);
                r_last_cand <= AW'(i_job.peak_idx);
                r_i <= '0;
                r_total <= '0;
                r_cum <= '0;
            end
            tsamp_pkg::B_PASS1: r_i <= r_i + CW'(1);
            tsamp_pkg::B_PRE: begin
                r_utot <= 50'(r_u * r_total[16:0]);
                r_thr <= {i_min_p, 16'd0} - 32'(i_min_p);
                r_i <= '0;
            end
            tsamp_pkg::B_PRE2: r_utot <= r_utot + {33'(r_u * r_total[33:17]), 17'd0};
            tsamp_pkg::B_PASS2: begin
                if (r_i < r_count) r_i <= r_i + CW'(1);
                if (r_q1 && w_cand) begin
                    r_cum <= w_cum_new;
                    r_last_cand <= r_qa;
                end
                if (w_hit) r_res <= r_qa;
                else if (w_end) r_res <= w_cand ? r_qa : r_last_cand;
            end
            default: ;
        endcase
    end

    assign o_valid = r_out_valid;
    assign o_index = r_out_idx;
endmodule

// ===== sv/token_min_p_sampler_core.sv =====
// Min-p token sampler. Slave stream: one signed Q8.8 logit per word, in index
// order; tlast marks the final logit of a vector, whose word also carries the
// Q0.16 uniform draw. Master stream: one word per vector with the chosen index.
// Config port: i_cfg_we/i_cfg_idx/i_cfg_data; 0 mode, 1 inverse temperature,
// 2 min-p ratio. Write only while idle.
// Logits load at one word per cycle into the logit store. After tlast the
// input holds off until the back end has released the store.
// Greedy mode: the job skips both passes; the done state loads the output.
// Min-p mode: the weight pass (one store read per cycle, five-stage exp
// pipeline) is followed by the cumulative walk, which stops at the first hit
// or at the last logit, and the done state then loads the output register,
// which holds the chosen index; each store has a single read port.
// Reset restores the register defaults and clears the vector state; the
// stores need no clearing. While the receiver stalls, the result holds in the
// output register and the next vector may still load.
// Depends on tsamp_pkg, tsamp_front, tsamp_fifo, tsamp_back.
`include "token_min_p_sampler_core_assert.svh"

module token_min_p_sampler_core #(
    parameter int VOCAB_DEPTH = tsamp_pkg::VOCAB_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [15:0] logit, [31:16] uniform_draw
    input  logic        i_s_axis_tlast,   // is_last
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [17:0] token_index, [23:18] zero
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    localparam int AW = $clog2(VOCAB_DEPTH);

    logic        r_mode;
    logic [15:0] r_inv_temp;
    logic [15:0] r_min_p;

    logic            w_wr_en;
    logic [AW-1:0]   w_wr_addr;
    logic [15:0]     w_wr_data;
    logic            w_push;
    logic            w_pop;
    logic            w_full;
    logic            w_job_valid;
    logic            w_release;
    tsamp_pkg::t_job w_job_in;
    tsamp_pkg::t_job w_job_out;
    logic [tsamp_pkg::TOKEN_W-1:0] w_index;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= tsamp_pkg::RST_MODE;
            r_inv_temp <= tsamp_pkg::RST_INV_TEMP;
            r_min_p <= tsamp_pkg::RST_MIN_P;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tsamp_pkg::CFG_MODE:     r_mode <= i_cfg_data[0];
                tsamp_pkg::CFG_INV_TEMP: r_inv_temp <= i_cfg_data;
                tsamp_pkg::CFG_MIN_P:    r_min_p <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tsamp_front #(.VOCAB_DEPTH(VOCAB_DEPTH)) u_front (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_s_axis_tvalid),
        .o_ready(o_s_axis_tready),
        .i_logit(i_s_axis_tdata[15:0]),
        .i_udraw(i_s_axis_tdata[31:16]),
        .i_last(i_s_axis_tlast),
        .i_mode(r_mode),
        .o_wr_en(w_wr_en),
        .o_wr_addr(w_wr_addr),
        .o_wr_data(w_wr_data),
        .o_push(w_push),
        .o_job(w_job_in),
        .i_full(w_full),
        .i_release(w_release)
    );

    tsamp_fifo u_fifo (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_push(w_push),
        .i_job(w_job_in),
        .o_full(w_full),
        .i_pop(w_pop),
        .o_valid(w_job_valid),
        .o_job(w_job_out)
    );

    tsamp_back #(.VOCAB_DEPTH(VOCAB_DEPTH)) u_back (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_job_valid(w_job_valid),
        .i_job(w_job_out),
        .o_pop(w_pop),
        .o_release(w_release),
        .i_wr_en(w_wr_en),
        .i_wr_addr(w_wr_addr),
        .i_wr_data(w_wr_data),
        .i_inv_temp(r_inv_temp),
        .i_min_p(r_min_p),
        .o_valid(o_m_axis_tvalid),
        .i_ready(i_m_axis_tready),
        .o_index(w_index)
    );

    assign o_m_axis_tdata = {6'd0, w_index};

    `TSAMP_ASSERT_IMPLY(a_ready_not_full, i_clk, i_rst_n, o_s_axis_tready, !w_full)
    `TSAMP_ASSERT_IMPLY(a_pop_out_free, i_clk, i_rst_n, w_pop, !o_m_axis_tvalid && w_job_valid)
    `TSAMP_ASSERT_NEXT(a_release_gives_out, i_clk, i_rst_n, w_release, o_m_axis_tvalid)
endmodule

// ===== tb/token_min_p_sampler_core_chk.sv =====
// Checker for the min-p token sampler: watches both streams, predicts the
// chosen index of each vector and compares. Depends on tsamp_pkg.
module token_min_p_sampler_core_chk (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_valid,
    input  logic        i_s_ready,
    input  logic [31:0] i_s_data,
    input  logic        i_s_last,
    input  logic        i_m_valid,
    input  logic        i_m_ready,
    input  logic [23:0] i_m_data,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    output int          o_fail_cnt,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = tsamp_pkg::VOCAB_DEPTH_DEF;

    localparam int EXP_I[12] = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60, 22, 8, 3, 1};
    localparam int EXP_H[16] = '{65536, 61565, 57835, 54331, 51039, 47947, 45042, 42313,
                                 39750, 37341, 35079, 32954, 30957, 29081, 27319, 25664};
    localparam int EXP_L[16] = '{65536, 65280, 65026, 64772, 64520, 64268, 64018, 63768,
                                 63520, 63272, 63025, 62780, 62535, 62291, 62048, 61806};

    logic        cur_mode;
    logic [15:0] cur_inv_temp;
    logic [15:0] cur_min_p;
    logic signed [15:0] vec_logits[$];
    logic [17:0] token_q[$];

    function automatic logic [15:0] exp_weight(input logic [15:0] diff,
                                               input logic [15:0] inv_t);
        longint s;
        longint w;
        s = (longint'(diff) * longint'(inv_t)) >> 8;
        if (s > 65535) s = 65535;
        if ((s >> 8) >= 12) return 16'd0;
        w = 65535;
        w = (w * EXP_I[s >> 8] + 32768) >> 16;
        w = (w * EXP_H[(s >> 4) & 15] + 32768) >> 16;
        w = (w * EXP_L[s & 15] + 32768) >> 16;
        return 16'(w);
    endfunction

    function automatic logic [17:0] pick_token(input logic [15:0] udraw);
        int peak_v;
        int peak_i;
        int last_c;
        longint total;
        longint cum;
        longint thr;
        logic [15:0] w[];
        peak_v = -32768;
        peak_i = 0;
        foreach (vec_logits[k])
            if (int'(vec_logits[k]) > peak_v) begin
                peak_v = vec_logits[k];
                peak_i = k;
            end
        if (cur_mode == tsamp_pkg::MODE_GREEDY) return 18'(peak_i);
        w = new[vec_logits.size()];
        total = 0;
        foreach (vec_logits[k]) begin
            w[k] = exp_weight(16'(peak_v - int'(vec_logits[k])), cur_inv_temp);
            total += w[k];
        end
        thr = longint'(cur_min_p) * 65535;
        last_c = peak_i;
        cum = 0;
        foreach (w[k])
            if (longint'(w[k]) * 65536 >= thr) begin
                last_c = k;
                cum += w[k];
                if (cum * 65536 > longint'(udraw) * total) return 18'(k);
            end
        return 18'(last_c);
    endfunction

    assign o_pending = token_q.size();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cur_mode     <= tsamp_pkg::RST_MODE;
            cur_inv_temp <= tsamp_pkg::RST_INV_TEMP;
            cur_min_p    <= tsamp_pkg::RST_MIN_P;
            o_fail_cnt   <= 0;
            vec_logits.delete();
            token_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    tsamp_pkg::CFG_MODE:     cur_mode     <= i_cfg_data[0];
                    tsamp_pkg::CFG_INV_TEMP: cur_inv_temp <= i_cfg_data;
                    tsamp_pkg::CFG_MIN_P:    cur_min_p    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_s_valid && i_s_ready) begin
                if (vec_logits.size() < DEPTH)
                    vec_logits = {vec_logits, signed'(i_s_data[15:0])};
                if (i_s_last) begin
                    token_q = {token_q, pick_token(i_s_data[31:16])};
                    vec_logits.delete();
                end
            end
            if (i_m_valid && i_m_ready) begin
                if (token_q.size() == 0) begin
                    $error("token_index: unexpected word, actual %0d", i_m_data[17:0]);
                    o_fail_cnt <= o_fail_cnt + 1;
                end else begin
                    if (token_q[0] !== i_m_data[17:0]) begin
                        $error("token_index: expected %0d, actual %0d",
                               token_q[0], i_m_data[17:0]);
                        o_fail_cnt <= o_fail_cnt + 1;
                    end
                    void'(token_q.pop_front());
                end
            end
        end
    end
endmodule

// ===== tb/token_min_p_sampler_core_tb.sv =====
// Testbench top for the min-p token sampler: drives logit vectors and
// register settings, stalls the result stream; checker module compares.
module token_min_p_sampler_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint LIMIT = 2000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_data = '0;
    logic        s_last = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [23:0] m_data;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_idx = tsamp_pkg::CFG_MODE;
    logic [15:0] cfg_data = '0;
    int          fail_cnt;
    int          pending;
    longint      cycle_cnt = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    token_min_p_sampler_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_valid), .o_s_axis_tready(s_ready),
        .i_s_axis_tdata(s_data), .i_s_axis_tlast(s_last),
        .o_m_axis_tvalid(m_valid), .i_m_axis_tready(m_ready),
        .o_m_axis_tdata(m_data),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    token_min_p_sampler_core_chk u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_valid(s_valid), .i_s_ready(s_ready), .i_s_data(s_data), .i_s_last(s_last),
        .i_m_valid(m_valid), .i_m_ready(m_ready), .i_m_data(m_data),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_fail_cnt(fail_cnt), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver stall pattern: alternating ready and stall runs
    initial begin
        int run;
        forever begin
            run = $urandom_range(0, 3) == 0 ? $urandom_range(1, 40) : $urandom_range(1, 4);
            repeat (run) @(posedge i_clk) m_ready <= 1'b1;
            run = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 12);
            repeat (run) @(posedge i_clk) m_ready <= 1'b0;
        end
    end

    int burst_left = 0;

    task automatic send_word(input logic [15:0] logit, input logic [15:0] udraw,
                             input logic last);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(0, 2) == 0 ? $urandom_range(1, 6) : 0) @(posedge i_clk);
            burst_left = $urandom_range(1, 20);
        end
        s_valid <= 1'b1;
        s_data  <= {udraw, logit};
        s_last  <= last;
        @(negedge i_clk);
        while (!s_ready) @(negedge i_clk);
        @(posedge i_clk);
        burst_left--;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        s_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] rand_logit(input int style);
        case (style)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 2047));
            default: return 16'(16'sd1000 - 16'($urandom_range(0, 600)));
        endcase
    endfunction

    task automatic send_vector(input int len, input int style, input logic [15:0] udraw);
        for (int k = 0; k < len; k++)
            send_word(rand_logit(style), udraw, k == len - 1);
    endtask

    initial begin
        int sent;
        int len;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, ties, single-item vectors, both modes
        send_word(16'h8000, 16'h0000, 1'b1);
        send_word(16'h7FFF, 16'hFFFF, 1'b1);
        send_word(16'h0100, 16'h0000, 1'b0);
        send_word(16'h0100, 16'h8000, 1'b0);
        send_word(16'h8000, 16'hFFFF, 1'b1);
        send_word(16'h7FFF, 16'h1234, 1'b0);
        send_word(16'h8000, 16'h1234, 1'b0);
        send_word(16'h7FFF, 16'hFFFF, 1'b1);
        write_reg(tsamp_pkg::CFG_INV_TEMP, 16'd0);
        send_vector(5, 0, 16'hC000);
        write_reg(tsamp_pkg::CFG_INV_TEMP, 16'hFFFF);
        write_reg(tsamp_pkg::CFG_MIN_P, 16'd0);
        send_vector(5, 1, 16'hFFFF);
        write_reg(tsamp_pkg::CFG_MIN_P, 16'hFFFF);
        send_vector(4, 2, 16'h0000);
        write_reg(tsamp_pkg::CFG_MODE, 16'(tsamp_pkg::MODE_GREEDY));
        send_word(16'h0005, 16'h0, 1'b0);
        send_word(16'h0005, 16'h0, 1'b0);
        send_word(16'h0004, 16'h0, 1'b1);

        sent = 0;
        while (sent < 900) begin
            if ($urandom_range(0, 5) == 0) begin
                write_reg(tsamp_pkg::CFG_MODE, 16'($urandom_range(0, 1)));
                write_reg(tsamp_pkg::CFG_INV_TEMP,
                          $urandom_range(0, 3) == 0 ? 16'($urandom)
                                                    : 16'($urandom_range(1, 1024)));
                write_reg(tsamp_pkg::CFG_MIN_P,
                          $urandom_range(0, 3) == 0 ? 16'($urandom)
                                                    : 16'($urandom_range(0, 16384)));
            end
            len = $urandom_range(1, 24);
            send_vector(len, $urandom_range(0, 2), 16'($urandom));
            sent += len;
        end
        s_valid <= 1'b0;
        s_last  <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
